// ----- rtl/core/resp_stream_parser_assert.svh -----
// Assertion macros shared by the RESP stream parser modules.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef RESP_STREAM_PARSER_ASSERT_SVH
`define RESP_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTH
`define RSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RSP_ASSERT(lbl, prop, msg)
`define RSP_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rsp_pkg.sv -----
// Types and constants for the RESP stream parser.
// No dependencies; used by rsp_parser, rsp_out_fifo and resp_stream_parser.
package rsp_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_DONE    = 2'd1,
    EV_HEADER  = 2'd2,
    EV_ERROR   = 2'd3
  } rsp_event_e;

  typedef enum logic [1:0] {
    ET_SIMPLE = 2'd0,
    ET_ERRSTR = 2'd1,
    ET_INT    = 2'd2,
    ET_BULK   = 2'd3
  } rsp_elem_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MARKER = 2'd1,
    ERR_INT    = 2'd2,
    ERR_LEN    = 2'd3
  } rsp_err_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_MARK  = 4'd1,
    PH_TEXT  = 4'd2,
    PH_INT   = 4'd3,
    PH_BLEN  = 4'd4,
    PH_ACNT  = 4'd5,
    PH_BDATA = 4'd6,
    PH_BCR   = 4'd7,
    PH_BLF   = 4'd8
  } rsp_phase_e;

  typedef struct packed {
    logic        run_last;
    rsp_err_e    error_code;
    logic        end_of_message;
    logic [63:0] int_value;
    logic [7:0]  data_byte;
    rsp_elem_e   element_type;
    rsp_event_e  event_res;
  } rsp_result_t;

  // Results produced by one accepted byte: zero, one or two.
  typedef struct packed {
    logic [1:0]  cnt;
    rsp_result_t r0;
    rsp_result_t r1;
  } rsp_push_t;

endpackage

// ----- rtl/core/rsp_parser.sv -----
// Byte-level RESP2 parser state and result generation.
// Depends on rsp_pkg and resp_stream_parser_assert.svh.
`include "resp_stream_parser_assert.svh"

module rsp_parser #(
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  output rsp_pkg::rsp_push_t push_o
);

  rsp_pkg::rsp_phase_e   phase_q, phase_d;
  rsp_pkg::rsp_elem_e    type_q, type_d;
  logic [63:0]           acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  seen_q, seen_d;
  logic                  closed_q, closed_d;
  logic                  crp_q, crp_d;
  logic [LEN_BITS-1:0]   bulk_q, bulk_d;
  logic [COUNT_BITS-1:0] arr_q, arr_d;
  logic                  in_arr_q, in_arr_d;

  logic                  main_vld, pre_vld;
  rsp_pkg::rsp_result_t  main_r, pre_r;
  logic                  do_fail, do_done, do_clear, do_idle;
  rsp_pkg::rsp_err_e     fail_code;
  logic [63:0]           done_val;
  logic                  is_digit, closed_now, acc_nz, len_bad, cnt_bad, done_eom;
  logic [67:0]           acc10;
  logic [67:0]           limit;
  logic [63:0]           signed_val;
  logic [COUNT_BITS-1:0] arr_m1;
  logic [LEN_BITS-1:0]   bulk_m1;

  assign is_digit   = (byte_i >= rsp_pkg::CH_ZERO) && (byte_i <= rsp_pkg::CH_NINE);
  assign acc10      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                      + {64'd0, byte_i[3:0]};
  assign limit      = neg_q ? {4'd0, 1'b1, 63'd0} : {5'd0, 63'h7FFF_FFFF_FFFF_FFFF};
  assign acc_nz     = |acc_q;
  assign len_bad    = (neg_q && acc_nz) || (|acc_q[63:LEN_BITS]);
  assign cnt_bad    = (neg_q && acc_nz) || (|acc_q[63:COUNT_BITS]);
  assign signed_val = neg_q ? (64'd0 - acc_q) : acc_q;
  assign arr_m1     = arr_q - COUNT_BITS'(1);
  assign bulk_m1    = bulk_q - LEN_BITS'(1);
  assign closed_now = closed_q | crp_q;
  assign done_eom   = !in_arr_q || (arr_m1 == '0);

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    closed_d  = closed_q;
    crp_d     = crp_q;
    bulk_d    = bulk_q;
    arr_d     = arr_q;
    in_arr_d  = in_arr_q;
    main_vld  = 1'b0;
    main_r    = '0;
    pre_vld   = 1'b0;
    do_fail   = 1'b0;
    fail_code = rsp_pkg::ERR_NONE;
    do_done   = 1'b0;
    done_val  = '0;
    do_clear  = 1'b0;
    do_idle   = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        rsp_pkg::PH_IDLE, rsp_pkg::PH_MARK: begin
          do_clear = 1'b1;
          if (byte_i == rsp_pkg::CH_PLUS) begin
            type_d = rsp_pkg::ET_SIMPLE; phase_d = rsp_pkg::PH_TEXT;
          end else if (byte_i == rsp_pkg::CH_MINUS) begin
            type_d = rsp_pkg::ET_ERRSTR; phase_d = rsp_pkg::PH_TEXT;
          end else if (byte_i == rsp_pkg::CH_COLON) begin
            type_d = rsp_pkg::ET_INT; phase_d = rsp_pkg::PH_INT;
          end else if (byte_i == rsp_pkg::CH_DOLLAR) begin
            type_d = rsp_pkg::ET_BULK; phase_d = rsp_pkg::PH_BLEN;
          end else if (byte_i == rsp_pkg::CH_STAR && phase_q == rsp_pkg::PH_IDLE) begin
            type_d = rsp_pkg::ET_SIMPLE; phase_d = rsp_pkg::PH_ACNT;
          end else begin
            do_fail = 1'b1; fail_code = rsp_pkg::ERR_MARKER;
          end
        end
        rsp_pkg::PH_TEXT: begin
          if (crp_q && byte_i == rsp_pkg::CH_LF) begin
            do_done = 1'b1;
          end else begin
            // A lone CR becomes payload ahead of this byte's own result.
            pre_vld = crp_q;
            crp_d   = (byte_i == rsp_pkg::CH_CR);
            if (byte_i != rsp_pkg::CH_CR) begin
              main_vld            = 1'b1;
              main_r.event_res    = rsp_pkg::EV_PAYLOAD;
              main_r.element_type = type_q;
              main_r.data_byte    = byte_i;
            end
          end
        end
        rsp_pkg::PH_INT, rsp_pkg::PH_BLEN, rsp_pkg::PH_ACNT: begin
          if (crp_q && byte_i == rsp_pkg::CH_LF) begin
            if (phase_q == rsp_pkg::PH_INT) begin
              do_done  = 1'b1;
              done_val = signed_val;
            end else if (phase_q == rsp_pkg::PH_BLEN) begin
              if (len_bad) begin
                do_fail = 1'b1; fail_code = rsp_pkg::ERR_LEN;
              end else begin
                bulk_d   = acc_q[LEN_BITS-1:0];
                phase_d  = acc_nz ? rsp_pkg::PH_BDATA : rsp_pkg::PH_BCR;
                do_clear = 1'b1;
              end
            end else begin
              if (cnt_bad) begin
                do_fail = 1'b1; fail_code = rsp_pkg::ERR_LEN;
              end else begin
                main_vld         = 1'b1;
                main_r.event_res = rsp_pkg::EV_HEADER;
                main_r.int_value = acc_q;
                if (!acc_nz) begin
                  main_r.end_of_message = 1'b1;
                  do_idle               = 1'b1;
                end else begin
                  in_arr_d = 1'b1;
                  arr_d    = acc_q[COUNT_BITS-1:0];
                  phase_d  = rsp_pkg::PH_MARK;
                  do_clear = 1'b1;
                end
              end
            end
          end else begin
            crp_d    = 1'b0;
            closed_d = closed_now;
            if (byte_i == rsp_pkg::CH_CR) begin
              if (!seen_q) begin
                do_fail = 1'b1; fail_code = rsp_pkg::ERR_INT;
              end else begin
                crp_d = 1'b1;
              end
            end else if (closed_now) begin
              // Ignore text after the digits.
            end else if (is_digit) begin
              if (acc10 > limit) begin
                do_fail = 1'b1; fail_code = rsp_pkg::ERR_INT;
              end else begin
                acc_d  = acc10[63:0];
                seen_d = 1'b1;
              end
            end else if (byte_i == rsp_pkg::CH_MINUS && !neg_q && !seen_q) begin
              neg_d = 1'b1;
            end else if (!seen_q) begin
              do_fail = 1'b1; fail_code = rsp_pkg::ERR_INT;
            end else begin
              closed_d = 1'b1;
            end
          end
        end
        rsp_pkg::PH_BDATA: begin
          main_vld            = 1'b1;
          main_r.event_res    = rsp_pkg::EV_PAYLOAD;
          main_r.element_type = type_q;
          main_r.data_byte    = byte_i;
          bulk_d              = bulk_m1;
          if (bulk_m1 == '0) begin
            phase_d = rsp_pkg::PH_BCR;
          end
        end
        rsp_pkg::PH_BCR: begin
          if (byte_i == rsp_pkg::CH_CR) begin
            phase_d = rsp_pkg::PH_BLF;
          end else begin
            do_fail = 1'b1; fail_code = rsp_pkg::ERR_LEN;
          end
        end
        rsp_pkg::PH_BLF: begin
          if (byte_i == rsp_pkg::CH_LF) begin
            do_done = 1'b1;
          end else begin
            do_fail = 1'b1; fail_code = rsp_pkg::ERR_LEN;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_done) begin
        main_vld              = 1'b1;
        main_r.event_res      = rsp_pkg::EV_DONE;
        main_r.element_type   = type_q;
        main_r.int_value      = done_val;
        main_r.end_of_message = done_eom;
        if (in_arr_q) begin
          arr_d = arr_m1;
        end
        if (done_eom) begin
          do_idle = 1'b1;
        end else begin
          phase_d  = rsp_pkg::PH_MARK;
          do_clear = 1'b1;
        end
      end

      if (do_fail) begin
        main_vld              = 1'b1;
        main_r                = '0;
        main_r.event_res      = rsp_pkg::EV_ERROR;
        main_r.data_byte      = byte_i;
        main_r.end_of_message = 1'b1;
        main_r.error_code     = fail_code;
        do_idle               = 1'b1;
      end
    end

    if (do_clear || do_idle) begin
      acc_d    = '0;
      neg_d    = 1'b0;
      seen_d   = 1'b0;
      closed_d = 1'b0;
      crp_d    = 1'b0;
    end
    if (do_idle) begin
      phase_d  = rsp_pkg::PH_IDLE;
      type_d   = rsp_pkg::ET_SIMPLE;
      bulk_d   = '0;
      arr_d    = '0;
      in_arr_d = 1'b0;
    end
  end

  // Pending CR emitted as payload of the current text element.
  always_comb begin
    pre_r              = '0;
    pre_r.event_res    = rsp_pkg::EV_PAYLOAD;
    pre_r.element_type = type_q;
    pre_r.data_byte    = rsp_pkg::CH_CR;
  end

  // Pack results into push slots; mark the last one of this byte.
  always_comb begin
    push_o = '0;
    if (pre_vld) begin
      push_o.r0          = pre_r;
      push_o.r1          = main_r;
      push_o.cnt         = main_vld ? 2'd2 : 2'd1;
      push_o.r0.run_last = !main_vld;
      push_o.r1.run_last = 1'b1;
    end else if (main_vld) begin
      push_o.r0          = main_r;
      push_o.r0.run_last = 1'b1;
      push_o.cnt         = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rsp_pkg::PH_IDLE;
      type_q   <= rsp_pkg::ET_SIMPLE;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      seen_q   <= 1'b0;
      closed_q <= 1'b0;
      crp_q    <= 1'b0;
      bulk_q   <= '0;
      arr_q    <= '0;
      in_arr_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      seen_q   <= seen_d;
      closed_q <= closed_d;
      crp_q    <= crp_d;
      bulk_q   <= bulk_d;
      arr_q    <= arr_d;
      in_arr_q <= in_arr_d;
    end
  end

  `RSP_ASSERT_IMP(a_two_needs_cr, push_o.cnt == 2'd2,
    push_o.r0.data_byte == rsp_pkg::CH_CR && push_o.r0.event_res == rsp_pkg::EV_PAYLOAD,
    "two results without a pending CR")
  `RSP_ASSERT(a_fail_to_idle, accept_i && do_fail |=> phase_q == rsp_pkg::PH_IDLE && !in_arr_q,
    "error did not return parser to idle")
  `RSP_ASSERT_IMP(a_array_live, in_arr_q,
    phase_q != rsp_pkg::PH_IDLE && arr_q != '0, "array state without live count")

endmodule

// ----- rtl/core/rsp_out_fifo.sv -----
// Small result queue taking up to two results per cycle, draining one per cycle while ready_i is high.
// Depends on rsp_pkg and resp_stream_parser_assert.svh.
`include "resp_stream_parser_assert.svh"

module rsp_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsp_pkg::rsp_push_t   push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output rsp_pkg::rsp_result_t head_o
);

  rsp_pkg::rsp_result_t              mem_q [rsp_pkg::OutDepth];
  logic [rsp_pkg::OutPtrW-1:0]       wr_q, wr_d, rd_q, rd_d, wr_p1;
  logic [rsp_pkg::OutCntW-1:0]       cnt_q, cnt_d;
  logic                              pop;

  assign room_o  = cnt_q <= rsp_pkg::OutCntW'(rsp_pkg::OutDepth - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_p1   = wr_q + rsp_pkg::OutPtrW'(1);

  always_comb begin
    wr_d  = wr_q + rsp_pkg::OutPtrW'(push_i.cnt);
    rd_d  = rd_q + rsp_pkg::OutPtrW'(pop);
    cnt_d = cnt_q + rsp_pkg::OutCntW'(push_i.cnt) - rsp_pkg::OutCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `RSP_ASSERT(a_cnt_bound, cnt_q <= rsp_pkg::OutCntW'(rsp_pkg::OutDepth),
    "result queue count out of range")
  `RSP_ASSERT_IMP(a_push_room, push_i.cnt != 2'd0, room_o,
    "results pushed without room")

endmodule

// ----- rtl/core/resp_stream_parser.sv -----
// Top level of the RESP2 stream parser: byte stream in, parse events out.
// Depends on rsp_pkg, rsp_parser, rsp_out_fifo.
//
// Accepts one raw RESP2 byte per cycle and reports payload bytes, element
// completion (with the integer value of ':' elements), array headers (with
// the element count) and protocol errors. Every byte is decoded in the cycle
// it is accepted; its results land in a four-entry result queue whose head
// drives the master side. Most bytes give zero or one result and the block
// sustains one byte per clock while the master side is ready. A lone CR
// inside a text line followed by a byte other than CR or LF gives two
// results; the input stays ready while the queue has two free slots.
// Integer lines are accumulated with a shift-add times ten and a 68-bit
// overflow compare in the decode cycle. After any error the parser returns to
// idle and waits for a new type marker.
module resp_stream_parser #(
  parameter int unsigned LEN_BITS   = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] data_byte, [71:8] int_value, [72] end_of_message,
  // [74:73] error_code, [79:75] zero
  output logic [79:0] m_axis_tdata_o,
  output logic [3:0]  m_axis_tuser_o,  // [1:0] event_res, [3:2] element_type
  output logic        m_axis_tlast_o   // run_last: last result of one byte
);

  logic                 accept;
  logic                 room;
  rsp_pkg::rsp_push_t   push;
  rsp_pkg::rsp_result_t head;

  // Take a request only while the queue can absorb two results.
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  rsp_parser #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .push_o   (push)
  );

  rsp_out_fifo u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  // Pack the head result onto the output request.
  assign m_axis_tdata_o = {5'd0, head.error_code, head.end_of_message,
                           head.int_value, head.data_byte};
  assign m_axis_tuser_o = {head.element_type, head.event_res};
  assign m_axis_tlast_o = head.run_last;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for resp_stream_parser: RESP2 byte stream in, parse events out.
// Depends on rsp_pkg and the resp_stream_parser RTL; predicts every event in SystemVerilog.
module testbench;

  localparam int unsigned LEN_BITS    = 32;
  localparam int unsigned COUNT_BITS  = 32;
  localparam logic [63:0] LEN_MAX     = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_BITS) - 64'd1;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  resp_stream_parser #(
    .LEN_BITS  (LEN_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  logic [7:0]           tx_bytes[$];
  logic [7:0]           msg_q[$];
  rsp_pkg::rsp_result_t step_q[$];
  rsp_pkg::rsp_result_t pending_events[$];
  bit                   byte_taken = 1'b0;
  bit                   calm = 1'b0;
  int unsigned          mismatches = 0;
  int unsigned          cycle_cnt = 0;

  // Parser state mirror
  rsp_pkg::rsp_phase_e    phase_st;
  rsp_pkg::rsp_elem_e     elem_ty;
  logic [63:0]            acc;
  bit                     neg_sign;
  bit                     dig_seen;
  bit                     dig_closed;
  logic [LEN_BITS-1:0]    bulk_left;
  logic [COUNT_BITS-1:0]  arr_left;
  bit                     in_array;
  bit                     cr_pend;

  function automatic void clear_line();
    acc        = 64'd0;
    neg_sign   = 1'b0;
    dig_seen   = 1'b0;
    dig_closed = 1'b0;
    cr_pend    = 1'b0;
  endfunction

  function automatic void go_idle();
    phase_st  = rsp_pkg::PH_IDLE;
    elem_ty   = rsp_pkg::ET_SIMPLE;
    bulk_left = '0;
    arr_left  = '0;
    in_array  = 1'b0;
    clear_line();
  endfunction

  function automatic void add_result(input rsp_pkg::rsp_event_e ev,
                                     input rsp_pkg::rsp_elem_e ty,
                                     input logic [7:0] d, input logic [63:0] v,
                                     input logic eom, input rsp_pkg::rsp_err_e err);
    rsp_pkg::rsp_result_t r;
    r.run_last       = 1'b0;
    r.error_code     = err;
    r.end_of_message = eom;
    r.int_value      = v;
    r.data_byte      = d;
    r.element_type   = ty;
    r.event_res      = ev;
    step_q.push_back(r);
  endfunction

  function automatic void flag_error(input rsp_pkg::rsp_err_e err, input logic [7:0] b);
    add_result(rsp_pkg::EV_ERROR, rsp_pkg::ET_SIMPLE, b, 64'd0, 1'b1, err);
    go_idle();
  endfunction

  function automatic void finish_element(input logic [63:0] v);
    logic eom;
    eom = 1'b1;
    if (in_array) begin
      arr_left = arr_left - COUNT_BITS'(1);
      if (arr_left != '0) eom = 1'b0;
    end
    add_result(rsp_pkg::EV_DONE, elem_ty, 8'h00, v, eom, rsp_pkg::ERR_NONE);
    if (eom) begin
      go_idle();
    end else begin
      phase_st = rsp_pkg::PH_MARK;
      clear_line();
    end
  endfunction

  // Advance the mirror by one accepted byte and queue the events it causes.
  function automatic void parse_byte(input logic [7:0] b);
    logic [63:0] val;
    logic [63:0] lim;
    logic [63:0] dig;
    bit          neg_val;
    case (phase_st)
      rsp_pkg::PH_IDLE, rsp_pkg::PH_MARK: begin
        clear_line();
        if (b == rsp_pkg::CH_PLUS) begin
          elem_ty = rsp_pkg::ET_SIMPLE; phase_st = rsp_pkg::PH_TEXT;
        end else if (b == rsp_pkg::CH_MINUS) begin
          elem_ty = rsp_pkg::ET_ERRSTR; phase_st = rsp_pkg::PH_TEXT;
        end else if (b == rsp_pkg::CH_COLON) begin
          elem_ty = rsp_pkg::ET_INT; phase_st = rsp_pkg::PH_INT;
        end else if (b == rsp_pkg::CH_DOLLAR) begin
          elem_ty = rsp_pkg::ET_BULK; phase_st = rsp_pkg::PH_BLEN;
        end else if (b == rsp_pkg::CH_STAR && phase_st == rsp_pkg::PH_IDLE) begin
          elem_ty = rsp_pkg::ET_SIMPLE; phase_st = rsp_pkg::PH_ACNT;
        end else begin
          flag_error(rsp_pkg::ERR_MARKER, b);
        end
      end
      rsp_pkg::PH_TEXT: begin
        if (cr_pend && b == rsp_pkg::CH_LF) begin
          finish_element(64'd0);
        end else begin
          // a CR without LF turns into payload ahead of this byte
          if (cr_pend) begin
            add_result(rsp_pkg::EV_PAYLOAD, elem_ty, rsp_pkg::CH_CR, 64'd0, 1'b0,
                       rsp_pkg::ERR_NONE);
            cr_pend = 1'b0;
          end
          if (b == rsp_pkg::CH_CR) cr_pend = 1'b1;
          else add_result(rsp_pkg::EV_PAYLOAD, elem_ty, b, 64'd0, 1'b0, rsp_pkg::ERR_NONE);
        end
      end
      rsp_pkg::PH_INT, rsp_pkg::PH_BLEN, rsp_pkg::PH_ACNT: begin
        if (cr_pend && b == rsp_pkg::CH_LF) begin
          val     = neg_sign ? (64'd0 - acc) : acc;
          neg_val = neg_sign && (acc != 64'd0);
          if (phase_st == rsp_pkg::PH_INT) begin
            finish_element(val);
          end else if (phase_st == rsp_pkg::PH_BLEN) begin
            if (neg_val || acc > LEN_MAX) begin
              flag_error(rsp_pkg::ERR_LEN, b);
            end else begin
              bulk_left = acc[LEN_BITS-1:0];
              phase_st  = (acc != 64'd0) ? rsp_pkg::PH_BDATA : rsp_pkg::PH_BCR;
              clear_line();
            end
          end else if (neg_val || acc > COUNT_MAX) begin
            flag_error(rsp_pkg::ERR_LEN, b);
          end else if (acc == 64'd0) begin
            add_result(rsp_pkg::EV_HEADER, rsp_pkg::ET_SIMPLE, 8'h00, 64'd0, 1'b1,
                       rsp_pkg::ERR_NONE);
            go_idle();
          end else begin
            add_result(rsp_pkg::EV_HEADER, rsp_pkg::ET_SIMPLE, 8'h00, acc, 1'b0,
                       rsp_pkg::ERR_NONE);
            in_array = 1'b1;
            arr_left = acc[COUNT_BITS-1:0];
            phase_st = rsp_pkg::PH_MARK;
            clear_line();
          end
        end else begin
          if (cr_pend) begin
            cr_pend    = 1'b0;
            dig_closed = 1'b1;
          end
          if (b == rsp_pkg::CH_CR) begin
            if (!dig_seen) flag_error(rsp_pkg::ERR_INT, b);
            else cr_pend = 1'b1;
          end else if (dig_closed) begin
            // rest of the line is ignored
          end else if (b >= rsp_pkg::CH_ZERO && b <= rsp_pkg::CH_NINE) begin
            dig = {56'd0, b - rsp_pkg::CH_ZERO};
            lim = neg_sign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (acc > (lim - dig) / 64'd10) begin
              flag_error(rsp_pkg::ERR_INT, b);
            end else begin
              acc      = acc * 64'd10 + dig;
              dig_seen = 1'b1;
            end
          end else if (b == rsp_pkg::CH_MINUS && !neg_sign && !dig_seen) begin
            neg_sign = 1'b1;
          end else if (!dig_seen) begin
            flag_error(rsp_pkg::ERR_INT, b);
          end else begin
            dig_closed = 1'b1;
          end
        end
      end
      rsp_pkg::PH_BDATA: begin
        add_result(rsp_pkg::EV_PAYLOAD, elem_ty, b, 64'd0, 1'b0, rsp_pkg::ERR_NONE);
        bulk_left = bulk_left - LEN_BITS'(1);
        if (bulk_left == '0) phase_st = rsp_pkg::PH_BCR;
      end
      rsp_pkg::PH_BCR: begin
        if (b == rsp_pkg::CH_CR) phase_st = rsp_pkg::PH_BLF;
        else flag_error(rsp_pkg::ERR_LEN, b);
      end
      rsp_pkg::PH_BLF: begin
        if (b == rsp_pkg::CH_LF) finish_element(64'd0);
        else flag_error(rsp_pkg::ERR_LEN, b);
      end
      default: go_idle();
    endcase
    if (step_q.size() != 0) begin
      step_q[step_q.size() - 1].run_last = 1'b1;
      while (step_q.size() != 0) pending_events.push_back(step_q.pop_front());
    end
  endfunction

  // Message building
  function automatic void put_crlf();
    msg_q.push_back(rsp_pkg::CH_CR);
    msg_q.push_back(rsp_pkg::CH_LF);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endfunction

  // Random payload; never forms CR LF, but lone CRs show up often.
  function automatic void put_payload(input int unsigned n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) == 0) c = rsp_pkg::CH_CR;
      if (c == rsp_pkg::CH_LF && msg_q.size() != 0 && msg_q[$] == rsp_pkg::CH_CR) c = 8'h41;
      msg_q.push_back(c);
    end
  endfunction

  function automatic string num_text();
    longint v;
    string  s;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 13))
      0:  s = "9223372036854775807";
      1:  s = "-9223372036854775808";
      2:  s = "9223372036854775808";   // one past the top
      3:  s = "-9223372036854775809";  // one past the bottom
      4:  s = "-";
      5:  s = "--4";
      6:  s = "-0";
      7:  s = "";
      8:  s = $sformatf("%0dz%0d", $urandom_range(0, 99), $urandom_range(0, 9));
      9:  s = $sformatf("%0d%c7", $urandom_range(0, 999), 13);
      10: s = $sformatf("%0d", v);
      11: s = $sformatf("-%0d", $urandom_range(1, 99999));
      default: s = $sformatf("%0d", $urandom_range(0, 99999));
    endcase
    return s;
  endfunction

  function automatic void gen_element();
    int unsigned n;
    logic [7:0]  c;
    c = 8'($urandom_range(0, 255));
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    case ($urandom_range(0, 12))
      0, 1, 2: begin
        msg_q.push_back(rsp_pkg::CH_PLUS); put_payload(n); put_crlf();
      end
      3: begin
        msg_q.push_back(rsp_pkg::CH_MINUS); put_payload(n); put_crlf();
      end
      4, 5, 6: begin
        msg_q.push_back(rsp_pkg::CH_COLON); put_text(num_text()); put_crlf();
      end
      7, 8, 9, 10: begin
        msg_q.push_back(rsp_pkg::CH_DOLLAR);
        case ($urandom_range(0, 19))
          0: put_text("-1");
          1: put_text("4294967296");
          2: put_text("-0");
          default: put_text($sformatf("%0d", n));
        endcase
        put_crlf();
        put_payload(n);
        case ($urandom_range(0, 11))
          0: msg_q.push_back(rsp_pkg::CH_LF);
          1: begin msg_q.push_back(rsp_pkg::CH_CR); msg_q.push_back(c); end
          default: put_crlf();
        endcase
      end
      11: begin
        msg_q.push_back(rsp_pkg::CH_STAR); put_text("2"); put_crlf();
      end
      default: msg_q.push_back(c);
    endcase
  endfunction

  task automatic drain_wait();
    while (tx_bytes.size() != 0 || s_axis_tvalid_i || pending_events.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin : accept_blk
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      parse_byte(s_axis_tdata_i);
      byte_taken = 1'b1;
    end
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk_i) begin : result_blk
    rsp_pkg::rsp_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: tuser %h tdata %h tlast %b",
               m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", want.event_res, m_axis_tuser_o[1:0]);
        check_field("element_type", want.element_type, m_axis_tuser_o[3:2]);
        check_field("data_byte", want.data_byte, m_axis_tdata_o[7:0]);
        check_field("int_value", want.int_value, m_axis_tdata_o[71:8]);
        check_field("end_of_message", want.end_of_message, m_axis_tdata_o[72]);
        check_field("error_code", want.error_code, m_axis_tdata_o[74:73]);
        check_field("run_last", want.run_last, m_axis_tlast_o);
      end
    end
  end

  // Present the next request once the current one is taken; idle at random
  always @(negedge clk_i) begin : send_blk
    if (rst_ni && (!s_axis_tvalid_i || byte_taken)) begin
      byte_taken = 1'b0;
      if (tx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        s_axis_tdata_i  <= tx_bytes.pop_front();
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : stall_blk
    m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 15);
  end

  initial begin : stim_blk
    int unsigned sent;
    int unsigned batch_bytes;
    int unsigned batch;
    int unsigned k;
    logic [7:0]  c;
    rst_ni = 1'b0;
    go_idle();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Lone CR in a line, empty array, negative length, nested array,
    // unknown marker, line with no digit.
    put_text("+a"); msg_q.push_back(rsp_pkg::CH_CR); put_text("b"); put_crlf();
    put_text("*0"); put_crlf();
    put_text("$-1"); put_crlf();
    put_text("*1"); put_crlf(); msg_q.push_back(rsp_pkg::CH_STAR);
    put_text("?");
    msg_q.push_back(rsp_pkg::CH_COLON); msg_q.push_back(rsp_pkg::CH_CR);
    while (msg_q.size() != 0) tx_bytes.push_back(msg_q.pop_front());
    drain_wait();

    // Random messages in batches; drain fully after each one.
    sent  = 0;
    batch = 0;
    while (sent < RANDOM_BYTES) begin
      calm = (batch == 2);
      batch_bytes = 0;
      while (batch_bytes < 180) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: begin
            k = $urandom_range(0, 4);
            msg_q.push_back(rsp_pkg::CH_STAR);
            case ($urandom_range(0, 24))
              0: put_text("-2");
              1: put_text("4294967296");
              2: put_text("4294967295");
              3: put_text("-0");
              default: put_text($sformatf("%0d", k));
            endcase
            put_crlf();
            repeat (k) gen_element();
          end
          17, 18, 19: begin
            repeat ($urandom_range(1, 3)) begin
              c = 8'($urandom_range(0, 255));
              msg_q.push_back(c);
            end
          end
          default: gen_element();
        endcase
        if ($urandom_range(0, 9) == 0) begin
          c = 8'($urandom_range(0, 255));
          msg_q[$urandom_range(0, msg_q.size() - 1)] = c;
        end
        batch_bytes += msg_q.size();
        while (msg_q.size() != 0) tx_bytes.push_back(msg_q.pop_front());
      end
      sent += batch_bytes;
      batch++;
      drain_wait();
    end
    calm = 1'b0;

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
